// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the ordered array list checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define OALE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("oale check failed");

// next-cycle implication, disabled while reset is asserted
`define OALE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("oale check failed");

`endif

// ===== rtl/oale_pkg.sv =====
// ----------------------------------------------------------------------------
// oale_pkg
// types and constants shared by the ordered array list engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package oale_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int REQ_W        = 4;
    localparam int VAL_W        = 32;
    localparam int POS_W        = 5;
    localparam int STAT_W       = 3;
    localparam int LVL_W        = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_INS_FRONT = 4'd0,
        REQ_INS_END   = 4'd1,
        REQ_INS_AT    = 4'd2,
        REQ_DEL_FRONT = 4'd3,
        REQ_DEL_END   = 4'd4,
        REQ_DEL_AT    = 4'd5,
        REQ_DEL_FIRST = 4'd6,
        REQ_DEL_ALL   = 4'd7,
        REQ_READ      = 4'd8
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_BADPOS   = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    // what the move unit does with each entry streamed out of the array
    typedef enum logic [1:0] {
        MV_SHIFT_UP,
        MV_DEL_IDX,
        MV_DEL_FIRST,
        MV_DEL_ALL
    } mode_t;

    typedef struct packed {
        logic             start;
        logic             take;
        mode_t            mode;
        logic [VAL_W-1:0] match_val;
    } mv_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/oale_ram.sv =====
// ----------------------------------------------------------------------------
// oale_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/oale_mover.sv =====
// ----------------------------------------------------------------------------
// oale_mover
// shared compare and move unit: decides per streamed entry where it goes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oale_mover #(
    parameter int CAPACITY = oale_pkg::CAPACITY_DEF
) (
    input  wire logic                                            clk,
    input  wire logic                                            rst_n,
    input  wire oale_pkg::mv_ctl_t                               ctl,
    input  wire logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] src_idx,
    input  wire logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] target,
    input  wire logic [oale_pkg::VAL_W-1:0]                      rdata,
    output logic                                                 we,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0]   waddr,
    output logic [oale_pkg::VAL_W-1:0]                           wdata,
    output logic [$clog2(CAPACITY + 1)-1:0]                      removed
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [AW-1:0] dst_reg;
    logic [AW-1:0] dst_next;
    logic [CW-1:0] removed_reg;
    logic [CW-1:0] removed_next;
    logic          hit;
    logic          skip;

    assign hit = (rdata == ctl.match_val);

    always_comb
    begin
        case (ctl.mode)
            oale_pkg::MV_SHIFT_UP:  skip = 1'b0;
            oale_pkg::MV_DEL_IDX:   skip = (src_idx == target);
            oale_pkg::MV_DEL_FIRST: skip = hit && (removed_reg == '0);
            oale_pkg::MV_DEL_ALL:   skip = hit;
            default:                skip = 1'b0;
        endcase
    end

    always_comb
    begin
        we    = ctl.take && !skip;
        wdata = rdata;
        if (ctl.mode == oale_pkg::MV_SHIFT_UP)
        begin
            waddr = src_idx + AW'(1);
        end
        else
        begin
            waddr = dst_reg;
        end

        dst_next     = dst_reg;
        removed_next = removed_reg;
        if (ctl.start)
        begin
            dst_next     = '0;
            removed_next = '0;
        end
        else if (ctl.take)
        begin
            if (skip)
            begin
                removed_next = removed_reg + CW'(1);
            end
            else
            begin
                dst_next = dst_reg + AW'(1);
            end
        end
    end

    assign removed = removed_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_reg     <= '0;
            removed_reg <= '0;
        end
        else
        begin
            dst_reg     <= dst_next;
            removed_reg <= removed_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ordered_array_list_engine.sv =====
// sequence: a rejected or unused request goes to S_FIN, a read through S_RD and S_RDW, a delete
//   scans every entry then S_DRAIN and S_COMMIT, an insert the shifted entries then S_DRAIN and S_PUT
//   (an append goes straight to S_PUT), each ending in S_FIN, where the result is registered
// throughput: one request at a time, taken once the result is registered; scans move one entry a cycle
// reset: list empty, no result pending; entry contents stay unknown until written
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// bounded ordered list of signed values with positional insert, delete and read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_list_engine #(
    parameter int CAPACITY = oale_pkg::CAPACITY_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [oale_pkg::REQ_W-1:0]         req_type,
    input  wire logic signed [oale_pkg::VAL_W-1:0]  item_value,
    input  wire logic [oale_pkg::POS_W-1:0]         position,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [oale_pkg::STAT_W-1:0]             status,
    output logic [oale_pkg::LVL_W-1:0]              fill_level,
    output logic signed [oale_pkg::VAL_W-1:0]       read_value,
    output logic [oale_pkg::LVL_W-1:0]              removed_count,
    output logic                                    is_full,
    output logic                                    is_empty
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > oale_pkg::POS_W) ? CW : oale_pkg::POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_PUT,
        S_COMMIT,
        S_RD,
        S_RDW,
        S_FIN
    } state_t;

    state_t                       state_reg, state_next;
    oale_pkg::mode_t              mode_reg, mode_next;
    logic [oale_pkg::VAL_W-1:0]   val_reg, val_next;
    logic [AW-1:0]                src_reg, src_next;
    logic [AW-1:0]                src_d_reg, src_d_next;
    logic [AW-1:0]                end_reg, end_next;
    logic [AW-1:0]                at_reg, at_next;
    logic                         take_reg, take_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    oale_pkg::status_t            res_status_reg, res_status_next;
    logic [oale_pkg::VAL_W-1:0]   res_rd_reg, res_rd_next;
    logic [CW-1:0]                res_removed_reg, res_removed_next;

    logic                         out_valid_reg, out_valid_next;
    oale_pkg::status_t            status_reg, status_next;
    logic [oale_pkg::LVL_W-1:0]   fill_level_reg, fill_level_next;
    logic [oale_pkg::VAL_W-1:0]   read_value_reg, read_value_next;
    logic [oale_pkg::LVL_W-1:0]   removed_count_reg, removed_count_next;
    logic                         is_full_reg, is_full_next;
    logic                         is_empty_reg, is_empty_next;

    oale_pkg::req_t               req;
    oale_pkg::mv_ctl_t            mv_ctl;
    logic                         mv_start;
    logic                         mv_we;
    logic [AW-1:0]                mv_waddr;
    logic [oale_pkg::VAL_W-1:0]   mv_wdata;
    logic [CW-1:0]                mv_removed;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [oale_pkg::VAL_W-1:0]   ram_wdata;
    logic [oale_pkg::VAL_W-1:0]   ram_rdata;

    logic [XW-1:0]                pos_x;
    logic [XW-1:0]                cnt_x;
    logic [XW-1:0]                pos_m1;
    logic [AW-1:0]                cnt_m1;
    logic [AW-1:0]                ins_at;
    logic                         list_full;
    logic                         list_empty;
    logic                         ins_pos_bad;
    logic                         pos_bad;

    assign req        = oale_pkg::req_t'(req_type);
    assign pos_x      = XW'(position);
    assign cnt_x      = XW'(cnt_reg);
    assign pos_m1     = pos_x - XW'(1);
    assign cnt_m1     = AW'(cnt_reg - CW'(1));
    assign list_full  = (cnt_reg == CW'(CAPACITY));
    assign list_empty = (cnt_reg == '0);
    // positions are 1-based: insert accepts up to count+1, delete and read up to count
    assign ins_pos_bad = (pos_x == '0) || (pos_x > cnt_x + XW'(1));
    assign pos_bad     = (pos_x == '0) || (pos_x > cnt_x);

    always_comb
    begin
        case (req)
            oale_pkg::REQ_INS_FRONT: ins_at = '0;
            oale_pkg::REQ_INS_END:   ins_at = AW'(cnt_reg);
            default:                 ins_at = pos_m1[AW-1:0];
        endcase
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next         = state_reg;
        mode_next          = mode_reg;
        val_next           = val_reg;
        src_next           = src_reg;
        src_d_next         = src_reg;
        end_next           = end_reg;
        at_next            = at_reg;
        take_next          = 1'b0;
        cnt_next           = cnt_reg;
        res_status_next    = res_status_reg;
        res_rd_next        = res_rd_reg;
        res_removed_next   = res_removed_reg;
        out_valid_next     = out_valid_reg && !out_ready;
        status_next        = status_reg;
        fill_level_next    = fill_level_reg;
        read_value_next    = read_value_reg;
        removed_count_next = removed_count_reg;
        is_full_next       = is_full_reg;
        is_empty_next      = is_empty_reg;
        mv_start           = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    val_next         = item_value;
                    res_status_next  = oale_pkg::ST_OK;
                    res_rd_next      = '0;
                    res_removed_next = '0;
                    state_next       = S_FIN;
                    case (req)
                        oale_pkg::REQ_INS_FRONT, oale_pkg::REQ_INS_END, oale_pkg::REQ_INS_AT:
                        begin
                            if (list_full)
                            begin
                                res_status_next = oale_pkg::ST_FULL;
                            end
                            else if ((req == oale_pkg::REQ_INS_AT) && ins_pos_bad)
                            begin
                                res_status_next = oale_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                mode_next = oale_pkg::MV_SHIFT_UP;
                                at_next   = ins_at;
                                src_next  = cnt_m1;
                                end_next  = ins_at;
                                // appending needs no shift
                                if (cnt_x == XW'(ins_at))
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        oale_pkg::REQ_DEL_FRONT, oale_pkg::REQ_DEL_END, oale_pkg::REQ_DEL_AT,
                        oale_pkg::REQ_DEL_FIRST, oale_pkg::REQ_DEL_ALL:
                        begin
                            if (list_empty)
                            begin
                                res_status_next = oale_pkg::ST_EMPTY;
                            end
                            else if ((req == oale_pkg::REQ_DEL_AT) && pos_bad)
                            begin
                                res_status_next = oale_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                mv_start   = 1'b1;
                                src_next   = '0;
                                end_next   = cnt_m1;
                                state_next = S_SCAN;
                                case (req)
                                    oale_pkg::REQ_DEL_FRONT:
                                    begin
                                        mode_next = oale_pkg::MV_DEL_IDX;
                                        at_next   = '0;
                                    end
                                    oale_pkg::REQ_DEL_END:
                                    begin
                                        mode_next = oale_pkg::MV_DEL_IDX;
                                        at_next   = cnt_m1;
                                    end
                                    oale_pkg::REQ_DEL_AT:
                                    begin
                                        mode_next = oale_pkg::MV_DEL_IDX;
                                        at_next   = pos_m1[AW-1:0];
                                    end
                                    oale_pkg::REQ_DEL_FIRST:
                                    begin
                                        mode_next = oale_pkg::MV_DEL_FIRST;
                                    end
                                    default:
                                    begin
                                        mode_next = oale_pkg::MV_DEL_ALL;
                                    end
                                endcase
                            end
                        end
                        oale_pkg::REQ_READ:
                        begin
                            if (pos_bad)
                            begin
                                res_status_next = oale_pkg::ST_BADPOS;
                            end
                            else
                            begin
                                src_next   = pos_m1[AW-1:0];
                                state_next = S_RD;
                            end
                        end
                        default:
                        begin
                            res_status_next = oale_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // one ram read issued per cycle, its data handled by the mover in the cycle after
                take_next = 1'b1;
                if (src_reg == end_reg)
                begin
                    state_next = S_DRAIN;
                end
                else if (mode_reg == oale_pkg::MV_SHIFT_UP)
                begin
                    src_next = src_reg - AW'(1);
                end
                else
                begin
                    src_next = src_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                if (mode_reg == oale_pkg::MV_SHIFT_UP)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_PUT:
            begin
                cnt_next        = cnt_reg + CW'(1);
                res_status_next = oale_pkg::ST_OK;
                state_next      = S_FIN;
            end
            S_COMMIT:
            begin
                cnt_next         = cnt_reg - mv_removed;
                res_removed_next = mv_removed;
                if (mv_removed == '0)
                begin
                    res_status_next = oale_pkg::ST_NOTFOUND;
                end
                else
                begin
                    res_status_next = oale_pkg::ST_OK;
                end
                state_next = S_FIN;
            end
            S_RD:
            begin
                state_next = S_RDW;
            end
            S_RDW:
            begin
                res_rd_next = ram_rdata;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next     = 1'b1;
                    status_next        = res_status_reg;
                    fill_level_next    = oale_pkg::LVL_W'(cnt_reg);
                    read_value_next    = res_rd_reg;
                    removed_count_next = oale_pkg::LVL_W'(res_removed_reg);
                    is_full_next       = list_full;
                    is_empty_next      = list_empty;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            mode_reg          <= oale_pkg::MV_SHIFT_UP;
            val_reg           <= '0;
            src_reg           <= '0;
            src_d_reg         <= '0;
            end_reg           <= '0;
            at_reg            <= '0;
            take_reg          <= 1'b0;
            cnt_reg           <= '0;
            res_status_reg    <= oale_pkg::ST_OK;
            res_rd_reg        <= '0;
            res_removed_reg   <= '0;
            out_valid_reg     <= 1'b0;
            status_reg        <= oale_pkg::ST_OK;
            fill_level_reg    <= '0;
            read_value_reg    <= '0;
            removed_count_reg <= '0;
            is_full_reg       <= 1'b0;
            is_empty_reg      <= 1'b1;
        end
        else
        begin
            state_reg         <= state_next;
            mode_reg          <= mode_next;
            val_reg           <= val_next;
            src_reg           <= src_next;
            src_d_reg         <= src_d_next;
            end_reg           <= end_next;
            at_reg            <= at_next;
            take_reg          <= take_next;
            cnt_reg           <= cnt_next;
            res_status_reg    <= res_status_next;
            res_rd_reg        <= res_rd_next;
            res_removed_reg   <= res_removed_next;
            out_valid_reg     <= out_valid_next;
            status_reg        <= status_next;
            fill_level_reg    <= fill_level_next;
            read_value_reg    <= read_value_next;
            removed_count_reg <= removed_count_next;
            is_full_reg       <= is_full_next;
            is_empty_reg      <= is_empty_next;
        end
    end

    assign mv_ctl.start     = mv_start;
    assign mv_ctl.take      = take_reg;
    assign mv_ctl.mode      = mode_reg;
    assign mv_ctl.match_val = val_reg;

    oale_mover #(
        .CAPACITY (CAPACITY)
    ) u_mover (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mv_ctl),
        .src_idx (src_d_reg),
        .target  (at_reg),
        .rdata   (ram_rdata),
        .we      (mv_we),
        .waddr   (mv_waddr),
        .wdata   (mv_wdata),
        .removed (mv_removed)
    );

    // the inserted value lands after the shift has finished
    assign ram_we    = mv_we || (state_reg == S_PUT);
    assign ram_waddr = (state_reg == S_PUT) ? at_reg : mv_waddr;
    assign ram_wdata = (state_reg == S_PUT) ? val_reg : mv_wdata;

    oale_ram #(
        .WIDTH (oale_pkg::VAL_W),
        .DEPTH (CAPACITY)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign fill_level    = fill_level_reg;
    assign read_value    = read_value_reg;
    assign removed_count = removed_count_reg;
    assign is_full       = is_full_reg;
    assign is_empty      = is_empty_reg;

endmodule

`default_nettype wire

// ===== rtl/oale_checker.sv =====
// ----------------------------------------------------------------------------
// oale_checker
// port-level checks for the ordered array list engine, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module oale_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [oale_pkg::STAT_W-1:0]       status,
    input wire logic [oale_pkg::LVL_W-1:0]        fill_level,
    input wire logic signed [oale_pkg::VAL_W-1:0] read_value,
    input wire logic [oale_pkg::LVL_W-1:0]        removed_count,
    input wire logic                              is_empty
);

    // a stalled result holds its payload
    `OALE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(fill_level) && $stable(read_value))

    // one request at a time: never ready right after a transaction is taken
    `OALE_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    `OALE_ASSERT_IMP(a_empty_flag, clk, rst_n, out_valid, is_empty == (fill_level == '0))

    // a rejected request removes nothing and reads nothing
    `OALE_ASSERT_IMP(a_reject_clean, clk, rst_n, out_valid && (status != oale_pkg::ST_OK), (removed_count == '0) && (read_value == '0))

    `OALE_ASSERT_IMP(a_removed_ok, clk, rst_n, out_valid && (removed_count != '0), status == oale_pkg::ST_OK)

endmodule

bind ordered_array_list_engine oale_checker u_oale_checker (.*);

`default_nettype wire

// ===== tb/sv/ordered_array_list_checker.sv =====
// ----------------------------------------------------------------------------
// ordered_array_list_checker
// watches both channels of the list engine, predicts each result from the
// accepted requests and compares it field by field in arrival order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_array_list_checker #(
    parameter int CAP = oale_pkg::CAPACITY_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic [oale_pkg::REQ_W-1:0]          req_type,
    input  logic signed [oale_pkg::VAL_W-1:0]   item_value,
    input  logic [oale_pkg::POS_W-1:0]          position,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [oale_pkg::STAT_W-1:0]         status,
    input  logic [oale_pkg::LVL_W-1:0]          fill_level,
    input  logic signed [oale_pkg::VAL_W-1:0]   read_value,
    input  logic [oale_pkg::LVL_W-1:0]          removed_count,
    input  logic                                is_full,
    input  logic                                is_empty,
    output int                                  fail_count,
    output int                                  open_count,
    output int                                  fill_now
);
    import oale_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STAT_W-1:0]       status;
        logic [LVL_W-1:0]        level;
        logic signed [VAL_W-1:0] rd;
        logic [LVL_W-1:0]        removed;
        logic                    full;
        logic                    empty;
    } list_result_t;

    logic signed [VAL_W-1:0] list_mem [CAP];
    int                      list_len;
    list_result_t            pending_results [$];

    // remove one entry and pull the tail down
    function automatic void close_slot(input int at);
        int k;
        for (k = at; k + 1 < list_len; k++)
            list_mem[k] = list_mem[k + 1];
        list_len--;
    endfunction

    function automatic list_result_t apply_request(
        input logic [REQ_W-1:0]       req,
        input logic signed [VAL_W-1:0] val,
        input logic [POS_W-1:0]       pos
    );
        list_result_t res;
        status_t      st;
        int           at;
        int           k;
        int           w;
        int           idx;
        int           gone;
        res  = '0;
        st   = ST_OK;
        gone = 0;
        idx  = int'(pos);
        if (req <= REQ_INS_AT) begin
            if (list_len >= CAP) begin
                st = ST_FULL;
            end
            else begin
                at = list_len;
                if (req == REQ_INS_FRONT) begin
                    at = 0;
                end
                else if (req == REQ_INS_AT) begin
                    if (idx < 1 || idx > list_len + 1)
                        st = ST_BADPOS;
                    else
                        at = idx - 1;
                end
                if (st == ST_OK) begin
                    for (k = list_len; k > at; k--)
                        list_mem[k] = list_mem[k - 1];
                    list_mem[at] = val;
                    list_len++;
                end
            end
        end
        else if (req <= REQ_DEL_ALL) begin
            if (list_len == 0) begin
                st = ST_EMPTY;
            end
            else begin
                case (req)
                    REQ_DEL_FRONT:
                    begin
                        close_slot(0);
                        gone = 1;
                    end
                    REQ_DEL_END:
                    begin
                        list_len--;
                        gone = 1;
                    end
                    REQ_DEL_AT:
                    begin
                        if (idx < 1 || idx > list_len) begin
                            st = ST_BADPOS;
                        end
                        else begin
                            close_slot(idx - 1);
                            gone = 1;
                        end
                    end
                    REQ_DEL_FIRST:
                    begin
                        for (k = 0; k < list_len && list_mem[k] != val; k++)
                            ;
                        if (k < list_len) begin
                            close_slot(k);
                            gone = 1;
                        end
                        else begin
                            st = ST_NOTFOUND;
                        end
                    end
                    default:
                    begin
                        // compact in place, skipping every match
                        w = 0;
                        for (k = 0; k < list_len; k++) begin
                            if (list_mem[k] == val) begin
                                gone++;
                            end
                            else begin
                                list_mem[w] = list_mem[k];
                                w++;
                            end
                        end
                        list_len = w;
                        if (gone == 0)
                            st = ST_NOTFOUND;
                    end
                endcase
            end
        end
        else if (req == REQ_READ) begin
            if (idx < 1 || idx > list_len)
                st = ST_BADPOS;
            else
                res.rd = list_mem[idx - 1];
        end
        // unused request codes leave everything alone with an ok status
        res.status  = st;
        res.level   = LVL_W'(list_len);
        res.removed = LVL_W'(gone);
        res.full    = (list_len == CAP);
        res.empty   = (list_len == 0);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        list_result_t want;
        int           k;
        if (!rst_n) begin
            for (k = 0; k < CAP; k++)
                list_mem[k] = '0;
            list_len = 0;
            pending_results.delete();
            fail_count = 0;
            open_count = 0;
            fill_now   = 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (pending_results.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $display("unexpected result transaction: status %0d fill %0d",
                                 status, fill_level);
                    fail_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    if (status !== want.status || fill_level !== want.level ||
                        read_value !== want.rd || removed_count !== want.removed ||
                        is_full !== want.full || is_empty !== want.empty) begin
                        if (fail_count < REPORT_LIMIT)
                            $display("result mismatch: status %0d/%0d fill %0d/%0d ",
                                     want.status, status, want.level, fill_level,
                                     "read %0d/%0d removed %0d/%0d full %0b/%0b ",
                                     want.rd, read_value, want.removed, removed_count,
                                     want.full, is_full,
                                     "empty %0b/%0b (expected/actual)",
                                     want.empty, is_empty);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
                pending_results.push_back(apply_request(req_type, item_value, position));
            open_count = pending_results.size();
            fill_now   = list_len;
        end
    end

endmodule

// ===== tb/sv/ordered_array_list_engine_test.sv =====
// ----------------------------------------------------------------------------
// ordered_array_list_engine_test
// drives directed and phased random requests into the list engine with random
// idling on both channels and reports the checker's verdict
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_array_list_engine_test;
    import oale_pkg::*;

    localparam int CAP              = CAPACITY_DEF;
    localparam int RANDOM_ITEMS     = 530;
    localparam int PHASE_ITEMS      = 40;
    localparam int LONG_HOLD        = 300;
    localparam int HOLD_AFTER       = 40;
    localparam int SETTLE_CYCLES    = CAP + 12;
    localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 4'd9;
    localparam logic [REQ_W-1:0] REQ_UNUSED_LAST  = 4'd15;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

    typedef enum int {
        PH_GROW,
        PH_SHRINK,
        PH_MIX
    } phase_kind_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic [REQ_W-1:0]         req_type;
    logic signed [VAL_W-1:0]  item_value;
    logic [POS_W-1:0]         position;
    logic                     out_valid;
    logic                     out_ready;
    logic [STAT_W-1:0]        status;
    logic [LVL_W-1:0]         fill_level;
    logic signed [VAL_W-1:0]  read_value;
    logic [LVL_W-1:0]         removed_count;
    logic                     is_full;
    logic                     is_empty;

    int                       fail_count;
    int                       open_count;
    int                       fill_now;
    int                       delivered;
    int                       source_calm;
    int                       sink_calm;
    logic signed [VAL_W-1:0]  value_pool [4];

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    ordered_array_list_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .item_value    (item_value),
        .position      (position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .fill_level    (fill_level),
        .read_value    (read_value),
        .removed_count (removed_count),
        .is_full       (is_full),
        .is_empty      (is_empty)
    );

    ordered_array_list_checker #(.CAP(CAP)) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .item_value    (item_value),
        .position      (position),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .fill_level    (fill_level),
        .read_value    (read_value),
        .removed_count (removed_count),
        .is_full       (is_full),
        .is_empty      (is_empty),
        .fail_count    (fail_count),
        .open_count    (open_count),
        .fill_now      (fill_now)
    );

    // mostly short gaps, a few long ones, and now and then a calm stretch
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_req(
        input logic [REQ_W-1:0]        req,
        input logic signed [VAL_W-1:0] val,
        input logic [POS_W-1:0]        pos
    );
        int gap;
        gap = pick_gap(source_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type   <= req;
        item_value <= val;
        position   <= pos;
        in_valid   <= 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic wait_list_idle();
        in_valid <= 1'b0;
        do @(negedge clk); while (open_count != 0);
    endtask

    task automatic send_random(input phase_kind_t kind);
        int                      r;
        int                      ins_pct;
        int                      del_pct;
        logic [REQ_W-1:0]        req;
        logic signed [VAL_W-1:0] val;
        logic [POS_W-1:0]        pos;
        case (kind)
            PH_GROW:   begin ins_pct = 75; del_pct = 17; end
            PH_SHRINK: begin ins_pct = 20; del_pct = 65; end
            default:   begin ins_pct = 40; del_pct = 40; end
        endcase
        r = $urandom_range(0, 99);
        if (r < ins_pct)
            req = REQ_W'($urandom_range(int'(REQ_INS_FRONT), int'(REQ_INS_AT)));
        else if (r < ins_pct + del_pct)
            req = REQ_W'($urandom_range(int'(REQ_DEL_FRONT), int'(REQ_DEL_ALL)));
        else if (r < 97)
            req = REQ_READ;
        else
            req = REQ_W'($urandom_range(int'(REQ_UNUSED_FIRST), int'(REQ_UNUSED_LAST)));
        // values from a small pool so that match deletes find something
        if ($urandom_range(0, 99) < 75)
            val = value_pool[$urandom_range(0, 3)];
        else
            val = $urandom;
        if ($urandom_range(0, 99) < 85)
            pos = POS_W'($urandom_range(1, fill_now + 1));
        else
            pos = POS_W'($urandom_range(0, 31));
        send_req(req, val, pos);
    endtask

    // result sink with random stalls and one long hold-off
    initial
    begin
        int gap;
        bit held;
        out_ready   = 1'b0;
        delivered   = 0;
        sink_calm   = 0;
        held        = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            if (delivered == HOLD_AFTER && !held) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            gap = pick_gap(sink_calm);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            delivered++;
            @(negedge clk);
        end
    end

    initial
    begin
        int          sent;
        int          phase;
        int          i;
        phase_kind_t kind;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        req_type    = REQ_INS_FRONT;
        item_value  = '0;
        position    = '0;
        source_calm = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty list: every delete kind, a read, an unused code and two bad insert positions
        send_req(REQ_READ, 0, 1);
        send_req(REQ_DEL_FRONT, 0, 1);
        send_req(REQ_DEL_END, 0, 1);
        send_req(REQ_DEL_AT, 0, 1);
        send_req(REQ_DEL_FIRST, 0, 1);
        send_req(REQ_DEL_ALL, 0, 1);
        send_req(REQ_UNUSED_LAST, -1, 31);
        send_req(REQ_INS_AT, 1, 2);
        send_req(REQ_INS_AT, 1, 0);
        // build -1, max, 5, min, 5
        send_req(REQ_INS_FRONT, VAL_MAX, 1);
        send_req(REQ_INS_END, VAL_MIN, 1);
        send_req(REQ_INS_AT, 5, 2);
        send_req(REQ_INS_AT, -1, 1);
        send_req(REQ_INS_END, 5, 1);
        send_req(REQ_READ, 0, 0);
        send_req(REQ_READ, 0, 31);
        send_req(REQ_READ, 0, 5);
        send_req(REQ_READ, 0, 1);
        send_req(REQ_DEL_FIRST, 1234, 1);
        send_req(REQ_DEL_ALL, 5, 1);
        send_req(REQ_DEL_FIRST, -1, 1);
        send_req(REQ_DEL_AT, 0, 3);
        send_req(REQ_DEL_AT, 0, 2);
        send_req(REQ_DEL_END, 0, 1);

        sent = 0;
        for (phase = 0; sent < RANDOM_ITEMS; phase++) begin
            for (i = 0; i < 4; i++) begin
                case ($urandom_range(0, 7))
                    0:       value_pool[i] = VAL_MAX;
                    1:       value_pool[i] = VAL_MIN;
                    default: value_pool[i] = $urandom;
                endcase
            end
            if (phase < 3)
                kind = phase_kind_t'(phase);
            else
                kind = phase_kind_t'($urandom_range(int'(PH_GROW), int'(PH_MIX)));
            repeat (PHASE_ITEMS) send_random(kind);
            sent += PHASE_ITEMS;
            if (phase == 1 || $urandom_range(0, 3) == 0)
                wait_list_idle();
        end

        in_valid <= 1'b0;
        while (open_count != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ordered_array_list_engine regression: pass");
        else
            $display("ordered_array_list_engine regression: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("ordered_array_list_engine regression: fail");
        $finish;
    end

endmodule
